/* hdl/soc_pkg.sv */
// ----------------------------------------------------------------------------
// soc_pkg
// Shared sizes, types and helper functions for the subarray OR coverage block.
// ----------------------------------------------------------------------------
package soc_pkg;

	// Value width and size of the per-mask stores.
	localparam int BITS       = 12;
	localparam int MASK_COUNT = 4096;
	localparam int MASK_AW    = $clog2(MASK_COUNT);
	localparam int WIDE_W     = 17;

	// OR list geometry.
	localparam int LIST_DEPTH = BITS + 1;
	localparam int LIST_AW    = $clog2(LIST_DEPTH);
	localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

	// Per-rank counter index and field widths.
	localparam int RANK_AW  = $clog2(BITS + 1);
	localparam int CNT_W    = 4;
	localparam int WEIGHT_W = 16;
	localparam int REWARD_W = 11;
	localparam int PROD_W   = REWARD_W + WEIGHT_W;
	localparam int POT_W    = 43;
	localparam int TOTAL_W  = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

	// Actions carried by an input item.
	localparam logic [1:0] ACT_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_PUSH   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_WALK,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	// Count memory read tag, one per issued read.
	typedef struct packed {
		logic               v;
		logic               rep;
		logic [MASK_AW-1:0] addr;
	} rd_tag_t;

	// Last count memory write, kept for forwarding.
	typedef struct packed {
		logic               v;
		logic [MASK_AW-1:0] addr;
		logic [CNT_W-1:0]   data;
	} wr_tag_t;

	// Reward for a hit count: 1024 plus the halving bonus of repeat hits.
	function automatic logic [REWARD_W-1:0] reward_of(input logic [CNT_W-1:0] c);
		logic [REWARD_W-1:0] r;
		case (c)
			4'd0, 4'd1: r = 11'd1024;
			4'd2:       r = 11'd1280;
			4'd3:       r = 11'd1408;
			4'd4:       r = 11'd1472;
			4'd5:       r = 11'd1504;
			4'd6:       r = 11'd1520;
			4'd7:       r = 11'd1528;
			4'd8:       r = 11'd1532;
			4'd9:       r = 11'd1534;
			default:    r = 11'd1535;
		endcase
		return r;
	endfunction

	// Number of set bits of a mask.
	function automatic logic [RANK_AW-1:0] pop_of(input logic [MASK_AW-1:0] m);
		logic [RANK_AW-1:0] n;
		n = '0;
		for (int k = 0; k < MASK_AW; k++) begin
			n = n + RANK_AW'(m[k]);
		end
		return n;
	endfunction

endpackage

/* hdl/subarray_or_coverage.sv */
// ----------------------------------------------------------------------------
// subarray_or_coverage
// Tracks distinct ORs of all subarrays ending at each pushed value, counts
// mask hits in a memory and reports per-rank coverage and weighted potential.
// ----------------------------------------------------------------------------
// After reset the block sweeps both mask memories, clearing hit counts and
// setting every weight to one; it takes no item during that time. A weight
// write is done in the idle state. A push walks the current OR list entry
// by entry, reading and writing one mask per cycle in the count memory.
// A finish walks all MASK_COUNT (4096) masks one per cycle, waits for the
// accumulate pipeline to drain, then delivers BITS result items, one per
// cycle unless stalled; the walk also clears the counts, and the finish
// empties the OR list.
module subarray_or_coverage import soc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [15:0]         value,
	input  logic [15:0]         weight,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          rank,
	output logic [15:0]         rank_covered,
	output logic [15:0]         covered_total,
	output logic [42:0]         potential_total,
	output logic                last
);

	state_t state_q, state_d;

	// Memories.
	logic [CNT_W-1:0]    count_mem [MASK_COUNT];
	logic [WEIGHT_W-1:0] weight_mem [MASK_COUNT];
	logic [CNT_W-1:0]    cnt_rd;
	logic [WEIGHT_W-1:0] wgt_rd;

	// OR list, two banks used in turn.
	logic [BITS-1:0]  list_q [2][LIST_DEPTH];
	logic             bank_q;
	logic [LEN_W-1:0] len_q, i_q, n_q;
	logic [BITS-1:0]  x_q, prev_q;

	logic [MASK_AW-1:0] walk_q;
	logic [RANK_AW-1:0] r_q;

	rd_tag_t s1_q, rd_issue;
	wr_tag_t wr_q;

	logic                s2_v, s2_hit, s3_v, s3_hit;
	logic [REWARD_W-1:0] s2_reward;
	logic [WEIGHT_W-1:0] s2_weight;
	logic [RANK_AW-1:0]  s2_pop, s3_pop;
	logic [PROD_W-1:0]   s3_prod;

	logic [TOTAL_W-1:0] rank_cnt_q [BITS+1];
	logic [TOTAL_W-1:0] cov_q;
	logic [POT_W-1:0]   pot_q;

	logic             in_acc, out_acc;
	logic             push_last, keep, wgt_ok;
	logic [BITS-1:0]  cur_v, x_in;
	logic [CNT_W-1:0] cnt_cur, cnt_new;
	logic             cnt_we, wgt_we;
	logic [MASK_AW-1:0]  cnt_waddr, wgt_waddr;
	logic [CNT_W-1:0]    cnt_wdata;
	logic [WEIGHT_W-1:0] wgt_wdata;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign x_in    = value[BITS-1:0];
	assign cur_v   = list_q[bank_q][i_q[LIST_AW-1:0]] | x_q;
	assign keep    = (cur_v != prev_q) && (n_q < LEN_W'(LIST_DEPTH));
	assign push_last = (i_q == len_q - 1'b1);
	assign wgt_ok  = (WIDE_W'(value) < WIDE_W'(MASK_COUNT));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (walk_q == MASK_AW'(MASK_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc && action == ACT_PUSH && len_q != '0) state_d = ST_PUSH;
				else if (in_acc && action == ACT_FINISH) state_d = ST_WALK;
			end
			ST_PUSH: begin
				if (push_last) state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (walk_q == MASK_AW'(MASK_COUNT - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!s1_q.v && !s2_v && !s3_v) state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (out_acc && r_q == RANK_AW'(BITS)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs and count memory read issue.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_REPORT);
		rd_issue  = '0;
		if (state_q == ST_IDLE && in_acc && action == ACT_PUSH) begin
			rd_issue.v    = (WIDE_W'(x_in) < WIDE_W'(MASK_COUNT));
			rd_issue.addr = MASK_AW'(WIDE_W'(x_in));
		end else if (state_q == ST_PUSH && keep) begin
			rd_issue.v    = (WIDE_W'(cur_v) < WIDE_W'(MASK_COUNT));
			rd_issue.addr = MASK_AW'(WIDE_W'(cur_v));
		end else if (state_q == ST_WALK) begin
			rd_issue.v    = 1'b1;
			rd_issue.rep  = 1'b1;
			rd_issue.addr = walk_q;
		end
	end

	// Read-modify-write of the hit count, forwarding the previous write.
	always_comb begin
		cnt_cur = (wr_q.v && wr_q.addr == s1_q.addr) ? wr_q.data : cnt_rd;
		cnt_new = s1_q.rep ? '0 : ((cnt_cur == COUNT_MAX) ? COUNT_MAX : cnt_cur + 1'b1);
		cnt_we    = s1_q.v || state_q == ST_CLEAR;
		cnt_waddr = (state_q == ST_CLEAR) ? walk_q : s1_q.addr;
		cnt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_new;
		wgt_we    = (state_q == ST_CLEAR) ||
			(state_q == ST_IDLE && in_acc && action == ACT_WEIGHT && wgt_ok);
		wgt_waddr = (state_q == ST_CLEAR) ? walk_q : MASK_AW'(WIDE_W'(value));
		wgt_wdata = (state_q == ST_CLEAR) ? WEIGHT_W'(1) : weight;
	end

	// Count memory.
	always_ff @(posedge clk) begin
		if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
		if (rd_issue.v) cnt_rd <= count_mem[rd_issue.addr];
	end

	// Weight memory.
	always_ff @(posedge clk) begin
		if (wgt_we) weight_mem[wgt_waddr] <= wgt_wdata;
		if (rd_issue.v) wgt_rd <= weight_mem[rd_issue.addr];
	end

	// OR list banks.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && action == ACT_PUSH) begin
			list_q[!bank_q][0] <= x_in;
		end else if (state_q == ST_PUSH && keep) begin
			list_q[!bank_q][n_q[LIST_AW-1:0]] <= cur_v;
		end
	end

	// Control state, push sequencing and walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			bank_q  <= 1'b0;
			len_q   <= '0;
			i_q     <= '0;
			n_q     <= '0;
			walk_q  <= '0;
			r_q     <= '0;
			s1_q    <= '0;
			wr_q    <= '0;
			s2_v    <= 1'b0;
			s3_v    <= 1'b0;
		end else begin
			state_q <= state_d;
			s1_q    <= rd_issue;
			wr_q.v    <= s1_q.v;
			wr_q.addr <= s1_q.addr;
			wr_q.data <= cnt_new;
			s2_v    <= s1_q.v && s1_q.rep;
			s3_v    <= s2_v;
			unique case (state_q)
				ST_CLEAR: begin
					walk_q <= walk_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_acc && action == ACT_PUSH) begin
						n_q <= LEN_W'(1);
						i_q <= '0;
						if (len_q == '0) begin
							len_q  <= LEN_W'(1);
							bank_q <= !bank_q;
						end
					end else if (in_acc && action == ACT_FINISH) begin
						walk_q <= '0;
						len_q  <= '0;
					end
				end
				ST_PUSH: begin
					if (keep) n_q <= n_q + 1'b1;
					if (push_last) begin
						len_q  <= n_q + LEN_W'(keep);
						bank_q <= !bank_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_WALK: begin
					walk_q <= walk_q + 1'b1;
				end
				ST_DRAIN: begin
					r_q <= RANK_AW'(1);
				end
				ST_REPORT: begin
					if (out_acc) r_q <= r_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Push payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && action == ACT_PUSH) begin
			x_q    <= x_in;
			prev_q <= x_in;
		end else if (state_q == ST_PUSH && keep) begin
			prev_q <= cur_v;
		end
	end

	// Report pipeline: reward and weight, then product.
	always_ff @(posedge clk) begin
		s2_hit    <= (cnt_cur != '0) && (s1_q.addr != '0);
		s2_reward <= reward_of(cnt_cur);
		s2_weight <= wgt_rd;
		s2_pop    <= pop_of(s1_q.addr);
		s3_hit    <= s2_hit;
		s3_pop    <= s2_pop;
		s3_prod   <= PROD_W'(s2_reward) * PROD_W'(s2_weight);
	end

	// Coverage accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= '0;
			pot_q <= '0;
			for (int k = 0; k <= BITS; k++) rank_cnt_q[k] <= '0;
		end else if (state_q == ST_IDLE && in_acc && action == ACT_FINISH) begin
			cov_q <= '0;
			pot_q <= '0;
			for (int k = 0; k <= BITS; k++) rank_cnt_q[k] <= '0;
		end else if (s3_v && s3_hit) begin
			cov_q <= cov_q + 1'b1;
			pot_q <= pot_q + POT_W'(s3_prod);
			rank_cnt_q[s3_pop] <= rank_cnt_q[s3_pop] + 1'b1;
		end
	end

	// Result fields.
	assign rank            = 5'(r_q);
	assign rank_covered    = rank_cnt_q[r_q];
	assign covered_total   = cov_q;
	assign potential_total = pot_q;
	assign last            = (r_q == RANK_AW'(BITS));

	// No count read may be in flight while the memories are swept.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s1_q.v)
		else $error("count read in flight during clearing sweep");

	// The OR list never grows past its depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LIST_DEPTH))
		else $error("OR list length beyond depth");

	// Results are shown only after the accumulate pipeline is empty.
	a_report_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !s1_q.v && !s2_v && !s3_v)
		else $error("result shown with accumulation pending");

	// A finished walk always leaves an empty OR list.
	a_walk_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> len_q == '0)
		else $error("OR list not cleared by finish");

endmodule

/* bench/subarray_or_coverage_test.sv */
// ----------------------------------------------------------------------------
// subarray_or_coverage_test
// Drives weight writes, sequence pushes and finish requests into the block,
// predicts every report item from a behavioral copy of the block's state, and
// checks each delivered item field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module subarray_or_coverage_test;
	import soc_pkg::*;

	localparam int WATCH_LIMIT = 40000;
	localparam int LONG_HOLD   = 6000;
	localparam int RAND_ITEMS  = 430;

	// Action code that the block ignores.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// One report item as the block delivers it.
	typedef struct packed {
		logic [4:0]  rank;
		logic [15:0] rank_covered;
		logic [15:0] covered_total;
		logic [42:0] potential_total;
		logic        last;
	} report_t;

	// One row of the directed plan; reps repeats the item, shl doubles the value.
	typedef struct {
		logic [1:0]  act;
		logic [15:0] val;
		logic [15:0] wt;
		int          reps;
		bit          shl;
		bit          has_exp;
		int          cov;
		longint      pot;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  action = '0;
	logic [15:0] value = '0;
	logic [15:0] weight = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [4:0]  rank;
	logic [15:0] rank_covered;
	logic [15:0] covered_total;
	logic [42:0] potential_total;
	logic        last;

	// Predicted copy of the block's state.
	logic [BITS-1:0]     seq_list [LIST_DEPTH];
	int                  seq_len;
	logic [CNT_W-1:0]    hit_cnt [MASK_COUNT];
	logic [WEIGHT_W-1:0] mask_wt [MASK_COUNT];

	report_t   report_q[$];
	plan_row_t plan[$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;

	subarray_or_coverage u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .weight(weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.rank(rank), .rank_covered(rank_covered), .covered_total(covered_total),
		.potential_total(potential_total), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Append one row to the directed plan.
	task automatic add_row(input logic [1:0] a, input logic [15:0] v,
			input logic [15:0] w, input int reps, input bit shl, input bit has_exp,
			input int cov, input longint pot);
		plan_row_t row;
		row.act     = a;
		row.val     = v;
		row.wt      = w;
		row.reps    = reps;
		row.shl     = shl;
		row.has_exp = has_exp;
		row.cov     = cov;
		row.pot     = pot;
		plan.insert(plan.size(), row);
	endtask

	// Reward of a hit count: 1024 plus a halving bonus for each repeat hit.
	function automatic longint reward_for_count(input int c);
		longint r;
		longint b;
		r = 1024;
		b = 256;
		for (int s = 1; s < c && b != 0; s++) begin
			r += b;
			b >>= 1;
		end
		return r;
	endfunction

	// Apply one accepted item to the predicted state and queue its report items.
	task automatic apply_item(input logic [1:0] a, input logic [15:0] v,
			input logic [15:0] w);
		logic [BITS-1:0] fresh [LIST_DEPTH];
		logic [BITS-1:0] x;
		logic [BITS-1:0] o;
		int n;
		int per_rank [BITS+1];
		int cov;
		longint pot;
		report_t r;
		case (a)
			ACT_WEIGHT: begin
				if (v < MASK_COUNT)
					mask_wt[v] = w;
			end
			ACT_PUSH: begin
				x = v[BITS-1:0];
				fresh[0] = x;
				n = 1;
				for (int i = 0; i < seq_len; i++) begin
					o = seq_list[i] | x;
					if (fresh[n-1] != o && n < LIST_DEPTH) begin
						fresh[n] = o;
						n++;
					end
				end
				for (int i = 0; i < n; i++) begin
					if (hit_cnt[fresh[i]] != COUNT_MAX)
						hit_cnt[fresh[i]]++;
					seq_list[i] = fresh[i];
				end
				seq_len = n;
			end
			ACT_FINISH: begin
				foreach (per_rank[k]) per_rank[k] = 0;
				cov = 0;
				pot = 0;
				for (int m = 1; m < MASK_COUNT; m++) begin
					if (hit_cnt[m] != 0) begin
						cov++;
						per_rank[$countones(m)]++;
						pot += reward_for_count(hit_cnt[m]) * longint'(mask_wt[m]);
					end
				end
				for (int k = 1; k <= BITS; k++) begin
					r.rank = 5'(k);
					r.rank_covered = 16'(per_rank[k]);
					r.covered_total = 16'(cov);
					r.potential_total = 43'(pot);
					r.last = (k == BITS);
					report_q.insert(report_q.size(), r);
				end
				foreach (hit_cnt[m]) hit_cnt[m] = '0;
				seq_len = 0;
			end
			default: ;
		endcase
	endtask

	// Offer one item, wait for acceptance, then predict it.
	task automatic send_item(input logic [1:0] a, input logic [15:0] v,
			input logic [15:0] w);
		int gap;
		in_valid <= 1'b1;
		action <= a;
		value <= v;
		weight <= w;
		do @(posedge clk); while (in_stall);
		apply_item(a, v, w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pause the sender until every expected report item has arrived.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Receiver: check delivered items and drive stall bursts or a long hold-off.
	initial begin
		int burst;
		int held;
		report_t e;
		burst = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					report("report item with nothing expected");
				end else begin
					e = report_q.pop_front();
					if (rank != e.rank)
						report($sformatf("rank %0d, expected %0d", rank, e.rank));
					if (rank_covered != e.rank_covered)
						report($sformatf("rank %0d rank_covered %0d, expected %0d",
							e.rank, rank_covered, e.rank_covered));
					if (covered_total != e.covered_total)
						report($sformatf("rank %0d covered_total %0d, expected %0d",
							e.rank, covered_total, e.covered_total));
					if (potential_total != e.potential_total)
						report($sformatf("rank %0d potential_total %0d, expected %0d",
							e.rank, potential_total, e.potential_total));
					if (last != e.last)
						report($sformatf("rank %0d last %0b, expected %0b",
							e.rank, last, e.last));
				end
			end
			if (hold_req) begin
				out_stall <= 1'b1;
				for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: cycles with no accepted item on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("subarray_or_coverage_test: done, errors");
			$finish;
		end
	end

	// Main stimulus.
	initial begin
		int first_new;
		logic [15:0] v;
		logic [15:0] w;
		int pick;
		seq_len = 0;
		foreach (hit_cnt[m]) hit_cnt[m] = '0;
		foreach (mask_wt[m]) mask_wt[m] = 16'd1;

		// Directed plan: reset state, extremes, saturation and a full OR list.
		add_row(ACT_FINISH, 16'h0000, 16'h0000, 1, 0, 1, 0, 0);
		add_row(ACT_PUSH, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
		add_row(ACT_PUSH, 16'h0001, 16'h0000, 1, 0, 0, 0, 0);
		add_row(ACT_FINISH, 16'h0000, 16'h0000, 1, 0, 1, 1, 1024);
		add_row(ACT_WEIGHT, 16'h0001, 16'hFFFF, 1, 0, 0, 0, 0);
		add_row(ACT_WEIGHT, 16'hFFFF, 16'h0000, 1, 0, 0, 0, 0);
		add_row(ACT_SPARE, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0);
		add_row(ACT_PUSH, 16'h0001, 16'h0000, 17, 0, 0, 0, 0);
		add_row(ACT_FINISH, 16'h0000, 16'h0000, 1, 0, 1, 1, 1535 * 65535);
		add_row(ACT_PUSH, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0);
		add_row(ACT_PUSH, 16'h0001, 16'h0000, 12, 1, 0, 0, 0);
		add_row(ACT_PUSH, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
		add_row(ACT_WEIGHT, 16'h0FFF, 16'hFFFF, 1, 0, 0, 0, 0);
		add_row(ACT_SPARE, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
		add_row(ACT_FINISH, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			v = plan[i].val;
			for (int k = 0; k < plan[i].reps; k++) begin
				first_new = report_q.size();
				send_item(plan[i].act, v, plan[i].wt);
				// Hand-typed totals replace the predicted ones for these rows.
				if (plan[i].has_exp) begin
					for (int j = first_new; j < report_q.size(); j++) begin
						report_q[j].covered_total = 16'(plan[i].cov);
						report_q[j].potential_total = 43'(plan[i].pot);
					end
				end
				if (plan[i].shl)
					v = v << 1;
			end
		end

		// Random part: mostly pushes of sparse values, some weights, rare finishes.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 380)
				quiet = 1'b1;
			if (i == 150) begin
				hold_req = 1'b1;
				send_item(ACT_FINISH, 16'($urandom), 16'($urandom));
				continue;
			end
			if (i == 300)
				drain_reports();
			pick = $urandom_range(0, 99);
			w = 16'($urandom);
			if (pick < 3) begin
				send_item(ACT_FINISH, 16'($urandom), w);
			end else if (pick < 5) begin
				send_item(ACT_SPARE, 16'($urandom), w);
			end else if (pick < 20) begin
				if ($urandom_range(0, 4) == 0)
					v = 16'($urandom);
				else
					v = 16'($urandom_range(0, MASK_COUNT - 1));
				send_item(ACT_WEIGHT, v, w);
			end else begin
				case ($urandom_range(0, 3))
					0: v = 16'($urandom);
					1: v = 16'($urandom & $urandom);
					default: v = 16'($urandom & $urandom & $urandom);
				endcase
				send_item(ACT_PUSH, v, w);
			end
		end
		send_item(ACT_FINISH, 16'h0000, 16'h0000);
		in_valid <= 1'b0;

		while (report_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("subarray_or_coverage_test: done, clean");
		else
			$display("subarray_or_coverage_test: done, errors");
		$finish;
	end

endmodule
